// ===== src/sstf_pkg.sv =====
// shared types, constants and helpers of the sstf disk request scheduler
package sstf_pkg;

  localparam int DEPTH          = 8;
  localparam int TRACK_MAX      = 999;
  localparam int REQUESTER_BITS = 8;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TRK_W   = 10;
  localparam int REQ_IN_W = 8;
  localparam int OCC_W   = 4;
  localparam int LIM_W   = 4;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [TRK_W-1:0]          trk_t;
  typedef logic [REQUESTER_BITS-1:0] req_t;
  typedef logic [LIM_W-1:0]          lim_t;

  localparam lim_t LIMIT_RESET = lim_t'(8);

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_SERVICE = 1'b1
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t cmd;
    req_t      req;
    trk_t      trk;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t item;
  } cmd_q_t;

  typedef struct packed {
    req_t req;
    trk_t trk;
  } entry_t;

  function automatic trk_t track_dist(trk_t a, trk_t b);
    trk_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

// ===== src/sstf_front.sv =====
// input stage: takes commands, clamps the track to TRACK_MAX, holds them in a two entry queue
module sstf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [sstf_pkg::REQ_IN_W-1:0]  in_requester,
  input  logic [sstf_pkg::TRK_W-1:0]     in_track,
  output sstf_pkg::cmd_q_t               cmd_q,
  input  logic                           cmd_pop
);

  sstf_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  sstf_pkg::cmd_t item;
  logic           push;
  logic           pop;

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = cmd_pop && (fill_r != 2'd0);

  always_comb begin
    item.cmd = sstf_pkg::cmd_code_t'(in_command);
    item.req = sstf_pkg::req_t'(in_requester);
    if (in_track > sstf_pkg::trk_t'(sstf_pkg::TRACK_MAX)) begin
      item.trk = sstf_pkg::trk_t'(sstf_pkg::TRACK_MAX);
    end else begin
      item.trk = in_track;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign cmd_q.valid = (fill_r != 2'd0);
  assign cmd_q.item  = q_r[rd_ptr_r];

endmodule

// ===== src/sstf_back.sv =====
// execution engine: request store, nearest-track scan, compaction and result register
module sstf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sstf_pkg::LIM_W-1:0]    cfg_wdata,
  input  sstf_pkg::cmd_q_t              cmd_q,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [sstf_pkg::REQ_IN_W-1:0] out_served_requester,
  output logic [sstf_pkg::TRK_W-1:0]    out_served_track,
  output logic [sstf_pkg::OCC_W-1:0]    out_occupancy
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  sstf_pkg::cnt_t       count_r, count_nxt;
  sstf_pkg::trk_t       head_r, head_nxt;
  sstf_pkg::lim_t       limit_r;
  sstf_pkg::idx_t       cmp_idx_r, cmp_idx_nxt;
  sstf_pkg::idx_t       best_idx_r, best_idx_nxt;
  sstf_pkg::trk_t       best_dist_r, best_dist_nxt;
  sstf_pkg::entry_t     best_ent_r, best_ent_nxt;
  sstf_pkg::idx_t       sh_idx_r, sh_idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  sstf_pkg::status_t    out_status_r, out_status_nxt;
  sstf_pkg::req_t       out_req_r, out_req_nxt;
  sstf_pkg::trk_t       out_trk_r, out_trk_nxt;
  sstf_pkg::cnt_t       out_occ_r, out_occ_nxt;

  sstf_pkg::entry_t     mem_r [sstf_pkg::DEPTH];
  sstf_pkg::entry_t     rd_data_r;
  sstf_pkg::idx_t       rd_addr;
  logic                 mem_we;
  sstf_pkg::idx_t       mem_wa;
  sstf_pkg::entry_t     mem_wd;

  sstf_pkg::cnt_t       lim_eff;
  logic                 out_free;
  sstf_pkg::trk_t       cur_dist;
  logic                 take;
  sstf_pkg::idx_t       sel_idx;
  sstf_pkg::entry_t     sel_ent;

  assign out_free = !out_valid_r || out_ready;
  assign cur_dist = sstf_pkg::track_dist(rd_data_r.trk, head_r);
  assign take     = (cmp_idx_r == '0) || (cur_dist < best_dist_r);
  assign sel_idx  = take ? cmp_idx_r : best_idx_r;
  assign sel_ent  = take ? rd_data_r : best_ent_r;

  always_comb begin
    if (int'(limit_r) > sstf_pkg::DEPTH) begin
      lim_eff = sstf_pkg::cnt_t'(sstf_pkg::DEPTH);
    end else begin
      lim_eff = sstf_pkg::cnt_t'(limit_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    cmp_idx_nxt    = cmp_idx_r;
    best_idx_nxt   = best_idx_r;
    best_dist_nxt  = best_dist_r;
    best_ent_nxt   = best_ent_r;
    sh_idx_nxt     = sh_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_req_nxt    = out_req_r;
    out_trk_nxt    = out_trk_r;
    out_occ_nxt    = out_occ_r;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    cmd_pop        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_q.valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd_q.item.cmd == sstf_pkg::CMD_ADD) begin
            out_valid_nxt = 1'b1;
            out_req_nxt   = '0;
            out_trk_nxt   = head_r;
            if (count_r >= lim_eff) begin
              out_status_nxt = sstf_pkg::ST_FULL;
              out_occ_nxt    = count_r;
            end else begin
              mem_we         = 1'b1;
              mem_wa         = sstf_pkg::idx_t'(count_r);
              mem_wd.req     = cmd_q.item.req;
              mem_wd.trk     = cmd_q.item.trk;
              count_nxt      = count_r + sstf_pkg::cnt_t'(1);
              out_status_nxt = sstf_pkg::ST_ADDED;
              out_occ_nxt    = count_r + sstf_pkg::cnt_t'(1);
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sstf_pkg::ST_EMPTY;
            out_req_nxt    = '0;
            out_trk_nxt    = head_r;
            out_occ_nxt    = count_r;
          end else begin
            rd_addr     = '0;
            cmp_idx_nxt = '0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_idx_nxt  = sel_idx;
        best_ent_nxt  = sel_ent;
        best_dist_nxt = take ? cur_dist : best_dist_r;
        if (sstf_pkg::cnt_t'(cmp_idx_r) + sstf_pkg::cnt_t'(1) == count_r) begin
          if (sstf_pkg::cnt_t'(sel_idx) + sstf_pkg::cnt_t'(1) == count_r) begin
            state_nxt      = S_IDLE;
            count_nxt      = count_r - sstf_pkg::cnt_t'(1);
            head_nxt       = sel_ent.trk;
            out_valid_nxt  = 1'b1;
            out_status_nxt = sstf_pkg::ST_SERVED;
            out_req_nxt    = sel_ent.req;
            out_trk_nxt    = sel_ent.trk;
            out_occ_nxt    = count_r - sstf_pkg::cnt_t'(1);
          end else begin
            rd_addr    = sel_idx + sstf_pkg::idx_t'(1);
            sh_idx_nxt = sel_idx;
            state_nxt  = S_SHIFT;
          end
        end else begin
          rd_addr     = cmp_idx_r + sstf_pkg::idx_t'(1);
          cmp_idx_nxt = cmp_idx_r + sstf_pkg::idx_t'(1);
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = sh_idx_r;
        mem_wd = rd_data_r;
        if (sstf_pkg::cnt_t'(sh_idx_r) + sstf_pkg::cnt_t'(2) == count_r) begin
          state_nxt      = S_IDLE;
          count_nxt      = count_r - sstf_pkg::cnt_t'(1);
          head_nxt       = best_ent_r.trk;
          out_valid_nxt  = 1'b1;
          out_status_nxt = sstf_pkg::ST_SERVED;
          out_req_nxt    = best_ent_r.req;
          out_trk_nxt    = best_ent_r.trk;
          out_occ_nxt    = count_r - sstf_pkg::cnt_t'(1);
        end else begin
          rd_addr    = sh_idx_r + sstf_pkg::idx_t'(2);
          sh_idx_nxt = sh_idx_r + sstf_pkg::idx_t'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      limit_r     <= sstf_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_dist_r  <= best_dist_nxt;
    best_ent_r   <= best_ent_nxt;
    sh_idx_r     <= sh_idx_nxt;
    out_status_r <= out_status_nxt;
    out_req_r    <= out_req_nxt;
    out_trk_r    <= out_trk_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // request store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_served_requester = sstf_pkg::REQ_IN_W'(out_req_r);
  assign out_served_track     = out_trk_r;
  assign out_occupancy        = sstf_pkg::OCC_W'(out_occ_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= sstf_pkg::DEPTH)
    else $error("pending count above depth");

  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result register busy during a service");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0))
    else $error("scan with an empty store");

  a_serve_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_SCAN) |-> cmd_pop)
    else $error("service started without taking its command");

endmodule

// ===== src/sstf_disk_request_scheduler.sv =====
// top level of the shortest-seek-time-first disk request scheduler
// usage:
//   in_* channel (valid/ready) carries commands: in_command 0 adds the request
//   {in_requester, in_track}, 1 services the pending request nearest the head.
//   out_* channel (valid/ready) returns one result per command: status, served
//   requester, head track after the command and occupancy.
//   cfg_we/cfg_wdata write queue_limit; write only while the block is idle.
// command queue and engine steps:
//   a two entry command queue sits in front of the engine, so commands are
//   taken while the engine works or a result waits.
//   add or rejected or empty service: handled in the idle state, which
//   registers the result directly once the result register is free.
//   service of n pending entries at position p (from 0): dispatch, a scan of
//   all n entries, then compaction of the n-1-p entries above p, one at a time
//   through the single read port of the request store.
// reset: rst_n low clears the queue, the head track to 0 and queue_limit to 8.
// stall: while out_ready is low the result holds and the engine waits before
//   starting the next command; the command queue then fills and in_ready drops.
module sstf_disk_request_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [sstf_pkg::REQ_IN_W-1:0] in_requester,
  input  logic [sstf_pkg::TRK_W-1:0]    in_track,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [sstf_pkg::REQ_IN_W-1:0] out_served_requester,
  output logic [sstf_pkg::TRK_W-1:0]    out_served_track,
  output logic [sstf_pkg::OCC_W-1:0]    out_occupancy,
  input  logic                          cfg_we,
  input  logic [sstf_pkg::LIM_W-1:0]    cfg_wdata
);

  sstf_pkg::cmd_q_t cmd_q;
  logic             cmd_pop;

  sstf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_requester (in_requester),
    .in_track     (in_track),
    .cmd_q        (cmd_q),
    .cmd_pop      (cmd_pop)
  );

  sstf_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .cmd_q                (cmd_q),
    .cmd_pop              (cmd_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_served_requester (out_served_requester),
    .out_served_track     (out_served_track),
    .out_occupancy        (out_occupancy)
  );

endmodule
